/* rtl/slru_pkg.sv */
// package for the snooping lru cache tag controller
// constants, command and bus request codes, state enum and the controller command struct
`default_nettype none
package slru_pkg;
	localparam int SETS       = 128;
	localparam int WAYS       = 8;
	localparam int LINE_BYTES = 32;
	localparam int SET_W      = $clog2(SETS);
	localparam int WAY_W      = $clog2(WAYS);
	localparam int OFS_W      = $clog2(LINE_BYTES);
	localparam int TAG_W      = 32 - SET_W - OFS_W;
	localparam int AGE_W      = 4;
	localparam int CNT_W      = $clog2(WAYS + 1);
	localparam int ENT_W      = TAG_W + AGE_W + 1;
	localparam int ROW_W      = WAYS * ENT_W;

	localparam logic [2:0] CMD_RD        = 3'd0;
	localparam logic [2:0] CMD_WR        = 3'd1;
	localparam logic [2:0] CMD_SNOOP_RD  = 3'd2;
	localparam logic [2:0] CMD_SNOOP_WR  = 3'd3;
	localparam logic [2:0] CMD_SNOOP_RDX = 3'd4;
	localparam logic [2:0] CMD_FREE      = 3'd5;

	localparam logic [1:0] BREQ_NONE = 2'd0;
	localparam logic [1:0] BREQ_RD   = 2'd1;
	localparam logic [1:0] BREQ_WR   = 2'd2;
	localparam logic [1:0] BREQ_RDX  = 2'd3;

	typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP} state_t;

	typedef struct packed {
		logic capture;
		logic update;
	} ctrl_cmd_t;
endpackage
`default_nettype wire

/* rtl/snooping_lru_cache_tag_controller.sv */
// top level: snooping lru cache tag controller
// depends on slru_pkg, slru_ctrl, slru_dp, slru_ram
//
// usage:
//  s_axis carries one item per transfer: command, address, requester.
//  m_axis returns one result per item. own_id_we/own_id_wdata write own_id.
//  the accept edge also reads the set row (tags, ages, valid bits) from ram;
//  the lookup state then writes the updated row back, bumps the counters and
//  loads the output register, once that register is free or transferring.
//  because of the read-modify-write of the row, a new item is not taken
//  until the last one has been written back.
//  a result waiting in the output register does not block the next accept;
//  that item then holds in lookup until the waiting result transfers, and
//  the input stays not ready meanwhile.
//  reset clears the row-written flags, counters, own_id and control; a row
//  not yet written since reset reads as zero tags, ages and valid bits.
//  own_id is to be written only while no item is in flight; the block does not enforce this.
`default_nettype none
module snooping_lru_cache_tag_controller import slru_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         own_id_we,
	input  wire [2:0]   own_id_wdata,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire [39:0]  s_axis_tdata,  // command, address, requester, zero pad
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [87:0] m_axis_tdata   // hit, set_index, way, bus_request,
	                                   // is_write, probe_matches,
	                                   // probe_read_total, probe_write_total
);
	logic [2:0] own_id_q;
	logic       in_rdy, in_fire, out_fire, out_busy;
	ctrl_cmd_t  cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
		end else if (own_id_we) begin
			own_id_q <= own_id_wdata;
		end
	end

	assign s_axis_tready = in_rdy;
	assign in_fire = s_axis_tvalid & in_rdy;
	assign out_fire = m_axis_tvalid & m_axis_tready;
	assign m_axis_tvalid = out_busy;

	slru_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.out_busy(out_busy), .in_rdy(in_rdy), .cmd(cmd)
	);

	slru_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .own_id_q(own_id_q),
		.command(s_axis_tdata[2:0]), .address(s_axis_tdata[34:3]),
		.requester(s_axis_tdata[37:35]), .out_fire(out_fire),
		.out_busy(out_busy), .res_q(m_axis_tdata)
	);
endmodule
`default_nettype wire

/* rtl/slru_ram.sv */
// generic single-port-write ram with registered read
// no dependencies
`default_nettype none
module slru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/slru_ctrl.sv */
// controller state machine: idle, lookup
// depends on slru_pkg
`default_nettype none
module slru_ctrl import slru_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_fire,
	input  wire        out_fire,
	input  wire        out_busy,
	output logic       in_rdy,
	output ctrl_cmd_t  cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_fire) state_d = ST_LOOKUP;
			ST_LOOKUP: if (!out_busy || out_fire) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_rdy = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				in_rdy = 1'b1;
				cmd.capture = in_fire;
			end
			ST_LOOKUP: cmd.update = !out_busy || out_fire;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/slru_dp.sv */
// datapath: set rows in ram, row-written flags, lookup, lru update, snoop counters
// depends on slru_pkg and slru_ram
`default_nettype none
module slru_dp import slru_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  ctrl_cmd_t        cmd,
	input  wire [2:0]        own_id_q,
	input  wire [2:0]        command,
	input  wire [31:0]       address,
	input  wire [2:0]        requester,
	input  wire              out_fire,
	output logic             out_busy,
	output logic [87:0]      res_q
);
	logic [2:0]       cmd_q;
	logic [SET_W-1:0] set_q;
	logic [TAG_W-1:0] tag_q;
	logic             foreign_q;
	logic             row_ok_q;
	logic [SET_W-1:0] in_set, raddr;
	logic [ROW_W-1:0] row_rd, row_in, row_wr;
	logic [SETS-1:0]  written_q;
	logic [WAYS-1:0]  vrow, vnew;
	logic [31:0]      prd_q, pwr_q, prd_d, pwr_d;
	logic [TAG_W-1:0] tags [WAYS];
	logic [AGE_W-1:0] ages [WAYS];
	logic [AGE_W-1:0] nage [WAYS];
	logic [TAG_W-1:0] ntag [WAYS];
	logic             is_cpu, is_snp, hit, found0;
	logic [WAY_W-1:0] hway, zway, oway, way;
	logic [AGE_W-1:0] top, prev;
	logic [CNT_W-1:0] nmatch;
	logic [1:0]       busreq;
	logic             valid_out_q;

	assign in_set = address[OFS_W +: SET_W];
	assign raddr = cmd.capture ? in_set : set_q;

	slru_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_row (
		.clk(clk), .we(cmd.update), .waddr(set_q), .wdata(row_wr),
		.raddr(raddr), .rdata(row_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q     <= command;
			set_q     <= in_set;
			tag_q     <= address[31 -: TAG_W];
			foreign_q <= requester != own_id_q;
			row_ok_q  <= written_q[in_set];
		end
	end

	// a row never written since reset reads as all zero
	assign row_in = row_ok_q ? row_rd : '0;
	assign is_cpu = cmd_q == CMD_RD || cmd_q == CMD_WR;
	assign is_snp = (cmd_q == CMD_SNOOP_RD || cmd_q == CMD_SNOOP_WR
		|| cmd_q == CMD_SNOOP_RDX) && foreign_q;

	always_comb begin
		hit = 1'b0; hway = '0; found0 = 1'b0; zway = '0; oway = '0; top = '0;
		nmatch = '0;
		for (int i = 0; i < WAYS; i++) begin
			tags[i] = row_in[i*ENT_W +: TAG_W];
			ages[i] = row_in[i*ENT_W+TAG_W +: AGE_W];
			vrow[i] = row_in[i*ENT_W+TAG_W+AGE_W];
		end
		vnew = vrow;
		for (int i = 0; i < WAYS; i++) begin
			if (vrow[i] && tags[i] == tag_q) begin
				hit = 1'b1; hway = WAY_W'(i);
			end
			if (tags[i] == tag_q) begin
				if (vrow[i]) nmatch = nmatch + CNT_W'(1);
				if (is_snp && cmd_q != CMD_SNOOP_RD) vnew[i] = 1'b0;
			end
		end
		for (int i = WAYS-1; i >= 0; i--) begin
			if (ages[i] == '0) begin
				found0 = 1'b1; zway = WAY_W'(i);
			end
		end
		for (int i = 0; i < WAYS; i++) begin
			if (ages[i] > top) begin
				top = ages[i]; oway = WAY_W'(i);
			end
		end
		way = hit ? hway : (found0 ? zway : oway);
		prev = ages[way];
		for (int i = 0; i < WAYS; i++) begin
			ntag[i] = tags[i];
			nage[i] = ages[i];
			if (is_cpu) begin
				if (WAY_W'(i) == way) begin
					nage[i] = AGE_W'(1);
					if (!hit) ntag[i] = tag_q;
				end else if (prev != AGE_W'(1) && ages[i] != '0
					&& (prev == '0 || ages[i] < prev)) begin
					nage[i] = ages[i] + AGE_W'(1);
				end
			end
		end
		if (is_cpu) vnew[way] = 1'b1;
		if (!is_snp) nmatch = '0;
		for (int i = 0; i < WAYS; i++) begin
			row_wr[i*ENT_W +: TAG_W] = ntag[i];
			row_wr[i*ENT_W+TAG_W +: AGE_W] = nage[i];
			row_wr[i*ENT_W+TAG_W+AGE_W] = vnew[i];
		end
		busreq = BREQ_NONE;
		if (is_cpu) begin
			if (hit) busreq = (cmd_q == CMD_WR) ? BREQ_WR : BREQ_NONE;
			else busreq = (cmd_q == CMD_WR) ? BREQ_RDX : BREQ_RD;
		end
		prd_d = prd_q; pwr_d = pwr_q;
		if (is_snp) begin
			if (cmd_q == CMD_SNOOP_WR) pwr_d = pwr_q + 32'(nmatch);
			else prd_d = prd_q + 32'(nmatch);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			prd_q <= '0;
			pwr_q <= '0;
			valid_out_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				written_q[set_q] <= 1'b1;
				prd_q <= prd_d;
				pwr_q <= pwr_d;
				valid_out_q <= 1'b1;
			end else if (out_fire) begin
				valid_out_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			res_q <= {6'b0, pwr_d, prd_d, nmatch, cmd_q == CMD_WR && is_cpu,
				busreq, is_cpu ? way : WAY_W'(0), set_q, is_cpu & hit};
		end
	end

	assign out_busy = valid_out_q;
endmodule
`default_nettype wire

/* bench/snooping_lru_cache_tag_controller_tb.sv */
// testbench for the snooping lru cache tag controller: cpu lookups, fills, lru ages,
// snoop probes and invalidation checked against an in-bench tag/age predictor
// depends on slru_pkg and snooping_lru_cache_tag_controller
`timescale 1ns / 1ps
module snooping_lru_cache_tag_controller_tb;
	import slru_pkg::*;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] addr;
		logic [2:0]  req;
	} access_t;

	typedef struct packed {
		logic        hit;
		logic [6:0]  set_index;
		logic [2:0]  way;
		logic [1:0]  bus_req;
		logic        is_write;
		logic [3:0]  probe_cnt;
		logic [31:0] read_total;
		logic [31:0] write_total;
	} lookup_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        own_id_we = 0;
	logic [2:0]  own_id_wdata = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = 0;  // command, address, requester, zero pad
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [87:0] m_axis_tdata;      // hit, set_index, way, bus_request, is_write,
	                                // probe_matches, probe_read_total, probe_write_total

	snooping_lru_cache_tag_controller dut (
		.clk(clk), .arst_n(arst_n),
		.own_id_we(own_id_we), .own_id_wdata(own_id_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// predictor state
	logic [19:0] tag_mem [128][8];
	logic        line_valid [128][8];
	logic [3:0]  line_age [128][8];
	logic [31:0] read_probes, write_probes;
	logic [2:0]  self_id;

	access_t pending [$];
	lookup_t awaited [$];
	int errors = 0;
	int results_seen = 0;
	int snoop_hits = 0;
	int cpu_hits = 0;
	bit no_idle = 0;
	int hold_request = 0;
	logic [19:0] tag_base;

	initial forever #1 clk = ~clk;

	initial begin
		#2000000;
		$display("timeout at %0t", $time);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void touch(int s, int w);
		logic [3:0] prev;
		prev = line_age[s][w];
		if (prev == 1)
			return;
		line_age[s][w] = 4'd1;
		for (int i = 0; i < 8; i++)
			if (i != w && line_age[s][i] != 0 && (prev == 0 || line_age[s][i] < prev))
				line_age[s][i]++;
	endfunction

	function automatic lookup_t predict_lookup(access_t a);
		lookup_t r;
		int s, w;
		logic [19:0] t;
		logic [3:0] top;
		logic found;
		r = '0;
		s = int'(a.addr[11:5]);
		t = a.addr[31:12];
		r.set_index = a.addr[11:5];
		if (a.cmd == CMD_RD || a.cmd == CMD_WR) begin
			r.is_write = (a.cmd == CMD_WR);
			for (int i = 0; i < 8; i++)
				if (line_valid[s][i] && tag_mem[s][i] == t) begin
					r.hit = 1;
					r.way = 3'(i);
				end
			if (r.hit) begin
				r.bus_req = r.is_write ? BREQ_WR : BREQ_NONE;
				cpu_hits++;
			end else begin
				r.bus_req = r.is_write ? BREQ_RDX : BREQ_RD;
				found = 0;
				w = 0;
				for (int i = 0; i < 8; i++)
					if (!found && line_age[s][i] == 0) begin
						found = 1;
						w = i;
					end
				if (!found) begin
					top = 0;
					for (int i = 0; i < 8; i++)
						if (line_age[s][i] > top) begin
							top = line_age[s][i];
							w = i;
						end
				end
				r.way = 3'(w);
				tag_mem[s][w] = t;
				line_valid[s][w] = 1;
			end
			touch(s, int'(r.way));
		end else if ((a.cmd == CMD_SNOOP_RD || a.cmd == CMD_SNOOP_WR ||
				a.cmd == CMD_SNOOP_RDX) && a.req != self_id) begin
			for (int i = 0; i < 8; i++)
				if (tag_mem[s][i] == t) begin
					if (line_valid[s][i])
						r.probe_cnt++;
					if (a.cmd != CMD_SNOOP_RD)
						line_valid[s][i] = 0;
				end
			if (a.cmd == CMD_SNOOP_WR)
				write_probes = write_probes + 32'(r.probe_cnt);
			else
				read_probes = read_probes + 32'(r.probe_cnt);
			snoop_hits += int'(r.probe_cnt);
		end
		r.read_total = read_probes;
		r.write_total = write_probes;
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (no_idle || p < 65)
			return 0;
		if (p < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// sender
	int send_gap = 0;
	always @(posedge clk) begin
		if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 0;
			end else if (pending.size() != 0) begin
				access_t a;
				a = pending.pop_front();
				s_axis_tdata <= {5'b0, a.req, a.addr, a.cmd};
				s_axis_tvalid <= 1;
				send_gap = pick_gap();
			end else
				s_axis_tvalid <= 0;
		end
	end

	// receiver
	int hold_left = 0;
	int recv_gap = 0;
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= 1;
			recv_gap = pick_gap();
		end
	end

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	// monitor: predict on input transfer, compare on output transfer
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			awaited.push_back(predict_lookup(access_t'{cmd: s_axis_tdata[2:0],
				addr: s_axis_tdata[34:3], req: s_axis_tdata[37:35]}));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			lookup_t e, g;
			g = {m_axis_tdata[0], m_axis_tdata[7:1], m_axis_tdata[10:8],
				m_axis_tdata[12:11], m_axis_tdata[13], m_axis_tdata[17:14],
				m_axis_tdata[49:18], m_axis_tdata[81:50]};
			results_seen++;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t unexpected result %h", $time, m_axis_tdata);
			end else begin
				e = awaited.pop_front();
				check_field("hit", e.hit, g.hit);
				check_field("set_index", e.set_index, g.set_index);
				check_field("way", e.way, g.way);
				check_field("bus_request", e.bus_req, g.bus_req);
				check_field("is_write", e.is_write, g.is_write);
				check_field("probe_matches", e.probe_cnt, g.probe_cnt);
				check_field("probe_read_total", e.read_total, g.read_total);
				check_field("probe_write_total", e.write_total, g.write_total);
			end
		end
	end

	task automatic push(logic [2:0] c, logic [31:0] a, logic [2:0] r);
		access_t x;
		x.cmd = c;
		x.addr = a;
		x.req = r;
		pending.push_back(x);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending.size() != 0 || s_axis_tvalid || awaited.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_own_id(logic [2:0] v);
		@(posedge clk);
		own_id_we <= 1;
		own_id_wdata <= v;
		self_id = v;
		@(posedge clk);
		own_id_we <= 0;
	endtask

	task automatic random_phase(int n);
		logic [2:0] c;
		logic [31:0] a;
		tag_base = 20'($urandom);
		for (int k = 0; k < n; k++) begin
			c = $urandom_range(0, 99) < 55 ? 3'($urandom_range(0, 1))
				: 3'($urandom_range(2, 5));
			if ($urandom_range(0, 9) == 0)
				a = $urandom;
			else
				a = {tag_base ^ 20'($urandom_range(0, 11)), 7'($urandom_range(0, 3)),
					5'($urandom)};
			push(c, a, 3'($urandom_range(0, 7)));
		end
	endtask

	initial begin
		for (int s = 0; s < 128; s++)
			for (int w = 0; w < 8; w++) begin
				tag_mem[s][w] = 0;
				line_valid[s][w] = 0;
				line_age[s][w] = 0;
			end
		read_probes = 0;
		write_probes = 0;
		self_id = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		write_own_id(3'd5);

		// directed: extremes, every command, own snoop, eviction, invalidation
		push(CMD_RD, 32'h0000_0000, 0);
		push(CMD_RD, 32'h0000_0000, 0);
		push(CMD_WR, 32'h0000_001f, 0);
		push(CMD_WR, 32'hffff_ffff, 7);
		push(CMD_SNOOP_RD, 32'h0000_0000, 1);
		push(CMD_SNOOP_RD, 32'h0000_0000, 5);
		push(CMD_SNOOP_WR, 32'hffff_ffff, 5);
		push(CMD_SNOOP_RDX, 32'hffff_ffe0, 7);
		push(CMD_RD, 32'hffff_ffff, 0);
		push(CMD_FREE, 32'h1234_5678, 2);
		for (int t = 1; t <= 10; t++)
			push(t[0] ? CMD_WR : CMD_RD, {20'(t), 7'h40, 5'h0}, 0);
		push(CMD_SNOOP_WR, {20'd3, 7'h40, 5'h0}, 0);
		push(CMD_RD, {20'd3, 7'h40, 5'h0}, 0);
		push(CMD_SNOOP_RDX, {20'd0, 7'h00, 5'h0}, 2);
		drain();

		no_idle = 1;
		random_phase(300);
		drain();
		no_idle = 0;

		write_own_id(3'd7);
		random_phase(180);
		hold_request = 300;
		random_phase(180);
		drain();

		write_own_id(3'd0);
		random_phase(360);
		drain();

		write_own_id(3'd3);
		random_phase(360);
		drain();

		if (awaited.size() != 0) begin
			errors++;
			$display("%0t %0d results never arrived", $time, awaited.size());
		end
		$display("covered %0d results: %0d cpu hits, %0d snoop probe hits, four cache ids",
			results_seen, cpu_hits, snoop_hits);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
